// ===== hdl/foc_clarke_park_svpwm_unit_macros.svh =====
// ------------------------------------------------------------------------
// FOC transform unit assertion macros
// Concurrent check wrappers for the asserting file.
// ------------------------------------------------------------------------
`ifndef FOC_CLARKE_PARK_SVPWM_UNIT_MACROS_SVH
`define FOC_CLARKE_PARK_SVPWM_UNIT_MACROS_SVH

// Same-cycle implication, masked while in reset
`define FCPS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, active during reset as well
`define FCPS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fcps_pkg.sv =====
// ------------------------------------------------------------------------
// FOC transform package
// Widths, Q.30 constants, beat structs and rounding/saturation helpers.
// ------------------------------------------------------------------------
package fcps_pkg;

  // Sample width (Q1.(DW-1)) and transform constant scale
  localparam int DW     = 16;
  localparam int KSHIFT = 30;
  localparam int NFLD   = 7;

  // Stream data width, padded to whole bytes
  localparam int TDW = ((NFLD * DW + 7) / 8) * 8;

  // Sum width for Clarke inputs, product width, wide accumulator width
  localparam int SW = DW + 2;
  localparam int PW = 2 * DW;
  localparam int WW = DW + KSHIFT + 3;

  // Mode codes
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  // 1/3, 1/sqrt(3), sqrt(3)/2 in Q.30, rounded to nearest
  localparam logic signed [WW-1:0] K_THIRD      = WW'(64'sd357913941);
  localparam logic signed [WW-1:0] K_INV_SQRT3  = WW'(64'sd619925131);
  localparam logic signed [WW-1:0] K_HALF_SQRT3 = WW'(64'sd929887697);

  // Rounding offsets and saturation bounds
  localparam logic signed [WW-1:0] HALF_K = WW'(64'sd1 <<< (KSHIFT - 1));
  localparam logic signed [WW-1:0] HALF_D = WW'(64'sd1 <<< (DW - 2));
  localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SAT_LO = WW'(-(64'sd1 <<< (DW - 1)));

  // One input sample set
  typedef struct packed {
    logic              mode;
    logic signed [DW-1:0] phase_a;
    logic signed [DW-1:0] phase_b;
    logic signed [DW-1:0] phase_c;
    logic signed [DW-1:0] axis_q;
    logic signed [DW-1:0] axis_d;
    logic signed [DW-1:0] sin_angle;
    logic signed [DW-1:0] cos_angle;
  } smp_t;

  // Front-end result handed to the back end
  typedef struct packed {
    logic              mode;
    logic signed [DW-1:0] sn;
    logic signed [DW-1:0] cs;
    logic signed [DW-1:0] alpha;
    logic signed [DW-1:0] beta;
    logic signed [WW-1:0] hb;     // beta * sqrt(3)/2 at Q.30 scale
  } ab_t;

  // One result set
  typedef struct packed {
    logic signed [DW-1:0] out_alpha;
    logic signed [DW-1:0] out_beta;
    logic signed [DW-1:0] out_q;
    logic signed [DW-1:0] out_d;
    logic signed [DW-1:0] out_a;
    logic signed [DW-1:0] out_b;
    logic signed [DW-1:0] out_c;
  } res_t;

  // Clamp a wide value to the sample range
  function automatic logic signed [DW-1:0] sat(input logic signed [WW-1:0] x);
    if (x > SAT_HI) begin
      return DW'(SAT_HI);
    end else if (x < SAT_LO) begin
      return DW'(SAT_LO);
    end
    return DW'(x);
  endfunction

  // Round half up, drop KSHIFT fraction bits
  function automatic logic signed [WW-1:0] rnd_k(input logic signed [WW-1:0] x);
    return (x + HALF_K) >>> KSHIFT;
  endfunction

  // Round half up, drop DW-1 fraction bits
  function automatic logic signed [WW-1:0] rnd_d(input logic signed [WW-1:0] x);
    return (x + HALF_D) >>> (DW - 1);
  endfunction

endpackage

// ===== hdl/fcps_front.sv =====
// ------------------------------------------------------------------------
// FOC transform front end
// Three stages: forward Clarke or inverse Park, giving saturated alpha/beta.
// ------------------------------------------------------------------------
module fcps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcps_pkg::smp_t     in_smp,
  output logic               out_valid,
  input  logic               out_ready,
  output fcps_pkg::ab_t      out_ab
);

  typedef struct packed {
    logic                           mode;
    logic signed [fcps_pkg::DW-1:0] sn;
    logic signed [fcps_pkg::DW-1:0] cs;
    logic signed [fcps_pkg::SW-1:0] x;    // 2a - b - c
    logic signed [fcps_pkg::SW-1:0] y;    // b - c
    logic signed [fcps_pkg::PW-1:0] p0;   // s * vq
    logic signed [fcps_pkg::PW-1:0] p1;   // c * vd
    logic signed [fcps_pkg::PW-1:0] p2;   // c * vq
    logic signed [fcps_pkg::PW-1:0] p3;   // s * vd
  } st1_t;

  typedef struct packed {
    logic                           mode;
    logic signed [fcps_pkg::DW-1:0] sn;
    logic signed [fcps_pkg::DW-1:0] cs;
    logic signed [fcps_pkg::WW-1:0] mx;
    logic signed [fcps_pkg::WW-1:0] my;
    logic signed [fcps_pkg::DW-1:0] alpha_i;
    logic signed [fcps_pkg::DW-1:0] beta_i;
  } st2_t;

  st1_t          st1, st1_next;
  st2_t          st2, st2_next;
  fcps_pkg::ab_t st3, st3_next;
  logic          v1, v2, v3;
  logic          en1, en2, en3;

  // Stage enables: a stage loads when empty or when its beat moves on
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;
  assign out_ab    = st3;

  // Stage 1: Clarke input sums, inverse Park products
  always_comb begin
    st1_next.mode = in_smp.mode;
    st1_next.sn   = in_smp.sin_angle;
    st1_next.cs   = in_smp.cos_angle;
    st1_next.x    = (fcps_pkg::SW'(in_smp.phase_a) <<< 1)
                    - fcps_pkg::SW'(in_smp.phase_b) - fcps_pkg::SW'(in_smp.phase_c);
    st1_next.y    = fcps_pkg::SW'(in_smp.phase_b) - fcps_pkg::SW'(in_smp.phase_c);
    st1_next.p0   = fcps_pkg::PW'(in_smp.sin_angle) * fcps_pkg::PW'(in_smp.axis_q);
    st1_next.p1   = fcps_pkg::PW'(in_smp.cos_angle) * fcps_pkg::PW'(in_smp.axis_d);
    st1_next.p2   = fcps_pkg::PW'(in_smp.cos_angle) * fcps_pkg::PW'(in_smp.axis_q);
    st1_next.p3   = fcps_pkg::PW'(in_smp.sin_angle) * fcps_pkg::PW'(in_smp.axis_d);
  end

  // Stage 2: Clarke constant products, inverse Park round and clamp
  always_comb begin
    st2_next.mode    = st1.mode;
    st2_next.sn      = st1.sn;
    st2_next.cs      = st1.cs;
    st2_next.mx      = fcps_pkg::WW'(st1.x) * fcps_pkg::K_THIRD;
    st2_next.my      = fcps_pkg::WW'(st1.y) * fcps_pkg::K_INV_SQRT3;
    st2_next.alpha_i = fcps_pkg::sat(fcps_pkg::rnd_d(
                         fcps_pkg::WW'(st1.p1) - fcps_pkg::WW'(st1.p0)));
    st2_next.beta_i  = fcps_pkg::sat(fcps_pkg::rnd_d(
                         fcps_pkg::WW'(st1.p2) + fcps_pkg::WW'(st1.p3)));
  end

  // Stage 3: Clarke round and clamp, beta scaling for inverse Clarke
  always_comb begin
    st3_next.mode = st2.mode;
    st3_next.sn   = st2.sn;
    st3_next.cs   = st2.cs;
    st3_next.hb   = fcps_pkg::WW'(st2.beta_i) * fcps_pkg::K_HALF_SQRT3;
    if (st2.mode == fcps_pkg::MODE_INV) begin
      st3_next.alpha = st2.alpha_i;
      st3_next.beta  = st2.beta_i;
    end else begin
      st3_next.alpha = fcps_pkg::sat(fcps_pkg::rnd_k(st2.mx));
      st3_next.beta  = fcps_pkg::sat(fcps_pkg::rnd_k(st2.my));
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1 && in_valid) st1 <= st1_next;
    if (en2 && v1)       st2 <= st2_next;
    if (en3 && v2)       st3 <= st3_next;
  end

endmodule

// ===== hdl/fcps_back.sv =====
// ------------------------------------------------------------------------
// FOC transform back end
// Three stages: Park or inverse Clarke with min-max midpoint removal.
// ------------------------------------------------------------------------
module fcps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fcps_pkg::ab_t  in_ab,
  output logic           out_valid,
  input  logic           out_ready,
  output fcps_pkg::res_t out_res
);

  typedef struct packed {
    logic                           mode;
    logic signed [fcps_pkg::DW-1:0] alpha;
    logic signed [fcps_pkg::DW-1:0] beta;
    logic signed [fcps_pkg::PW-1:0] p0;   // s * alpha
    logic signed [fcps_pkg::PW-1:0] p1;   // c * beta
    logic signed [fcps_pkg::PW-1:0] p2;   // c * alpha
    logic signed [fcps_pkg::PW-1:0] p3;   // s * beta
    logic signed [fcps_pkg::WW-1:0] pa;
    logic signed [fcps_pkg::WW-1:0] pb;
    logic signed [fcps_pkg::WW-1:0] pc;
  } st4_t;

  typedef struct packed {
    logic                           mode;
    logic signed [fcps_pkg::DW-1:0] alpha;
    logic signed [fcps_pkg::DW-1:0] beta;
    logic signed [fcps_pkg::DW-1:0] q;
    logic signed [fcps_pkg::DW-1:0] d;
    logic signed [fcps_pkg::WW-1:0] pa;
    logic signed [fcps_pkg::WW-1:0] pb;
    logic signed [fcps_pkg::WW-1:0] pc;
    logic signed [fcps_pkg::WW-1:0] mid;
  } st5_t;

  st4_t                           st4, st4_next;
  st5_t                           st5, st5_next;
  fcps_pkg::res_t                 st6, st6_next;
  logic                           v4, v5, v6;
  logic                           en4, en5, en6;
  logic signed [fcps_pkg::WW-1:0] ha;
  logic signed [fcps_pkg::WW-1:0] pmax, pmin;
  logic signed [fcps_pkg::WW:0]   psum;

  // Stage enables
  assign en6       = !v6 || out_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign in_ready  = en4;
  assign out_valid = v6;
  assign out_res   = st6;

  // Stage 4: Park products, inverse Clarke phase sums at Q.30 scale
  always_comb begin
    ha             = fcps_pkg::WW'(in_ab.alpha) <<< (fcps_pkg::KSHIFT - 1);
    st4_next.mode  = in_ab.mode;
    st4_next.alpha = in_ab.alpha;
    st4_next.beta  = in_ab.beta;
    st4_next.p0    = fcps_pkg::PW'(in_ab.sn) * fcps_pkg::PW'(in_ab.alpha);
    st4_next.p1    = fcps_pkg::PW'(in_ab.cs) * fcps_pkg::PW'(in_ab.beta);
    st4_next.p2    = fcps_pkg::PW'(in_ab.cs) * fcps_pkg::PW'(in_ab.alpha);
    st4_next.p3    = fcps_pkg::PW'(in_ab.sn) * fcps_pkg::PW'(in_ab.beta);
    st4_next.pa    = fcps_pkg::WW'(in_ab.alpha) <<< fcps_pkg::KSHIFT;
    st4_next.pb    = in_ab.hb - ha;
    st4_next.pc    = -ha - in_ab.hb;
  end

  // Stage 5: Park round and clamp, midpoint of the phase extremes
  always_comb begin
    pmax = st4.pa;
    if (st4.pb > pmax) pmax = st4.pb;
    if (st4.pc > pmax) pmax = st4.pc;
    pmin = st4.pa;
    if (st4.pb < pmin) pmin = st4.pb;
    if (st4.pc < pmin) pmin = st4.pc;
    psum = (fcps_pkg::WW + 1)'(pmax) + (fcps_pkg::WW + 1)'(pmin);

    st5_next.mode  = st4.mode;
    st5_next.alpha = st4.alpha;
    st5_next.beta  = st4.beta;
    st5_next.pa    = st4.pa;
    st5_next.pb    = st4.pb;
    st5_next.pc    = st4.pc;
    st5_next.mid   = psum[fcps_pkg::WW:1];
    if (st4.mode == fcps_pkg::MODE_INV) begin
      st5_next.q = '0;
      st5_next.d = '0;
    end else begin
      st5_next.q = fcps_pkg::sat(fcps_pkg::rnd_d(
                     fcps_pkg::WW'(st4.p1) - fcps_pkg::WW'(st4.p0)));
      st5_next.d = fcps_pkg::sat(fcps_pkg::rnd_d(
                     fcps_pkg::WW'(st4.p2) + fcps_pkg::WW'(st4.p3)));
    end
  end

  // Stage 6: common-mode removal, round and clamp the phases
  always_comb begin
    st6_next.out_alpha = st5.alpha;
    st6_next.out_beta  = st5.beta;
    st6_next.out_q     = st5.q;
    st6_next.out_d     = st5.d;
    if (st5.mode == fcps_pkg::MODE_INV) begin
      st6_next.out_a = fcps_pkg::sat(fcps_pkg::rnd_k(st5.pa - st5.mid));
      st6_next.out_b = fcps_pkg::sat(fcps_pkg::rnd_k(st5.pb - st5.mid));
      st6_next.out_c = fcps_pkg::sat(fcps_pkg::rnd_k(st5.pc - st5.mid));
    end else begin
      st6_next.out_a = '0;
      st6_next.out_b = '0;
      st6_next.out_c = '0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en4 && in_valid) st4 <= st4_next;
    if (en5 && v4)       st5 <= st5_next;
    if (en6 && v5)       st6 <= st6_next;
  end

endmodule

// ===== hdl/foc_clarke_park_svpwm_unit.sv =====
// ------------------------------------------------------------------------
// FOC Clarke/Park transform unit with SVPWM midpoint injection
// Stream wrapper around the two three-stage halves of the datapath.
// ------------------------------------------------------------------------
// Each input beat carries one sample set and produces exactly one result
// beat; one beat is taken every cycle while the output is drained. The
// datapath has six register stages (three for Clarke or inverse Park,
// three for Park or inverse Clarke with common-mode removal), each stage
// holding its beat under back-pressure, so empty stages are
// filled while the output waits. tuser selects the mode: low for forward
// Clarke then Park, high for inverse Park then inverse Clarke with the
// min-max midpoint subtracted. Results a mode does not produce are zero.
module foc_clarke_park_svpwm_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // phase_a, phase_b, phase_c, axis_q, axis_d, sin_angle, cos_angle
  input  logic [fcps_pkg::TDW-1:0] s_axis_tdata,
  // mode
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // out_alpha, out_beta, out_q, out_d, out_a, out_b, out_c
  output logic [fcps_pkg::TDW-1:0] m_axis_tdata
);

  `include "foc_clarke_park_svpwm_unit_macros.svh"

  localparam int DW = fcps_pkg::DW;

  fcps_pkg::smp_t smp;
  fcps_pkg::ab_t  ab;
  fcps_pkg::res_t res;
  logic           ab_valid, ab_ready;

  // Unpack input beat
  always_comb begin
    smp.mode      = s_axis_tuser;
    smp.phase_a   = s_axis_tdata[0*DW +: DW];
    smp.phase_b   = s_axis_tdata[1*DW +: DW];
    smp.phase_c   = s_axis_tdata[2*DW +: DW];
    smp.axis_q    = s_axis_tdata[3*DW +: DW];
    smp.axis_d    = s_axis_tdata[4*DW +: DW];
    smp.sin_angle = s_axis_tdata[5*DW +: DW];
    smp.cos_angle = s_axis_tdata[6*DW +: DW];
  end

  fcps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_smp    (smp),
    .out_valid (ab_valid),
    .out_ready (ab_ready),
    .out_ab    (ab)
  );

  fcps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ab_valid),
    .in_ready  (ab_ready),
    .in_ab     (ab),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack result beat, alpha lowest
  assign m_axis_tdata = fcps_pkg::TDW'({res.out_c, res.out_b, res.out_a, res.out_d,
                                        res.out_q, res.out_beta, res.out_alpha});

  // Checks
  `FCPS_CHECK(a_stall_from_output, !s_axis_tready, m_axis_tvalid && !m_axis_tready && ab_valid && !ab_ready, "input stalled without a full pipe held by the output")
  `FCPS_CHECK(a_mode_zeros, m_axis_tvalid, (res.out_a == '0 && res.out_b == '0 && res.out_c == '0) || (res.out_q == '0 && res.out_d == '0), "result carries fields of both modes")
  `FCPS_CHECK_NEXT(a_reset_empty, rst, !m_axis_tvalid && !ab_valid, "pipeline not empty after reset")

endmodule

// ===== tb/sv/tb.sv =====
// ------------------------------------------------------------------------
// FOC Clarke/Park/SVPWM unit testbench
// Streams forward and inverse sample sets through the unit and checks
// every result beat, field by field, against a bit-exact transform
// predictor. Both sides of the stream idle at random.
// ------------------------------------------------------------------------
module tb;

  // Q.30 transform constants: 1/3, 1/sqrt(3), sqrt(3)/2, and one
  localparam longint Q30_THIRD      = 64'sd357913941;
  localparam longint Q30_INV_SQRT3  = 64'sd619925131;
  localparam longint Q30_HALF_SQRT3 = 64'sd929887697;
  localparam longint Q30_ONE        = 64'sd1 <<< 30;

  localparam int N_RANDOM       = 690;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 300;
  localparam int TAIL_ITEMS     = 80;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam int DW  = fcps_pkg::DW;
  localparam int TDW = fcps_pkg::TDW;

  typedef struct {
    fcps_pkg::smp_t smp;
    bit             drain_first;  // hold off until every result so far has arrived
  } queued_sample_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;
  logic           s_axis_tuser = 1'b0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [TDW-1:0] m_axis_tdata;

  queued_sample_t sample_q[$];
  fcps_pkg::res_t expected_res[int];
  fcps_pkg::smp_t cur_sample;
  int             n_items;
  int             samples_in = 0;
  int             results_out = 0;
  int             mismatches = 0;
  int             send_gap = 0;
  int             hold_left = 0;
  bit             long_hold_done = 1'b0;
  int             stall_cycles = 0;
  wire            idle_allowed;

  // Quiet window mid-run and a tail with no idling at all
  assign idle_allowed = !(samples_in >= 420 && samples_in < 480) &&
                        (samples_in + TAIL_ITEMS < n_items);

  foc_clarke_park_svpwm_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Round half up, dropping sh fraction bits
  function automatic longint round_shift(longint x, int sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Clamp to the sample range
  function automatic longint clamp_sample(longint x);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // Bit-exact forward (Clarke, Park) or inverse (Park, Clarke, SVPWM) result
  function automatic fcps_pkg::res_t foc_transform(fcps_pkg::smp_t s);
    longint         sn, cs, ia, ib, ic, vq, vd, al, be;
    longint         pa, pb, pc, mx, mn, mid;
    fcps_pkg::res_t r;
    r  = '0;
    sn = s.sin_angle;
    cs = s.cos_angle;
    if (s.mode == fcps_pkg::MODE_FWD) begin
      ia = s.phase_a;
      ib = s.phase_b;
      ic = s.phase_c;
      al = clamp_sample(round_shift((2 * ia - ib - ic) * Q30_THIRD, 30));
      be = clamp_sample(round_shift((ib - ic) * Q30_INV_SQRT3, 30));
      r.out_q = DW'(clamp_sample(round_shift(-(sn * al) + cs * be, DW - 1)));
      r.out_d = DW'(clamp_sample(round_shift(cs * al + sn * be, DW - 1)));
    end else begin
      vq = s.axis_q;
      vd = s.axis_d;
      al = clamp_sample(round_shift(-(sn * vq) + cs * vd, DW - 1));
      be = clamp_sample(round_shift(cs * vq + sn * vd, DW - 1));
      // phases at Q.30 scale, common mode = floor of min-max midpoint
      pa = al * Q30_ONE;
      pb = -(al * (Q30_ONE / 2)) + be * Q30_HALF_SQRT3;
      pc = -(al * (Q30_ONE / 2)) - be * Q30_HALF_SQRT3;
      mx = pa;
      mn = pa;
      if (pb > mx) mx = pb;
      if (pc > mx) mx = pc;
      if (pb < mn) mn = pb;
      if (pc < mn) mn = pc;
      mid = (mx + mn) >>> 1;
      r.out_a = DW'(clamp_sample(round_shift(pa - mid, 30)));
      r.out_b = DW'(clamp_sample(round_shift(pb - mid, 30)));
      r.out_c = DW'(clamp_sample(round_shift(pc - mid, 30)));
    end
    r.out_alpha = DW'(al);
    r.out_beta  = DW'(be);
    return r;
  endfunction

  // Field values weighted towards the extremes and small magnitudes
  function automatic logic signed [DW-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return DW'(-32768);
          1: return DW'(32767);
          2: return '0;
          3: return DW'(-1);
          default: return DW'(1);
        endcase
      end
      1, 2: return DW'(int'($urandom_range(0, 511)) - 256);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic add_sample(logic mode, int a, int b, int c, int q, int d,
                            int sn, int cs, bit drain);
    queued_sample_t it;
    it.smp.mode      = mode;
    it.smp.phase_a   = DW'(a);
    it.smp.phase_b   = DW'(b);
    it.smp.phase_c   = DW'(c);
    it.smp.axis_q    = DW'(q);
    it.smp.axis_d    = DW'(d);
    it.smp.sin_angle = DW'(sn);
    it.smp.cos_angle = DW'(cs);
    it.drain_first   = drain;
    sample_q.push_back(it);
  endtask

  task automatic check_field(string name, logic signed [DW-1:0] exp_v,
                             logic signed [DW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Sender: presents queued sample sets, holds each beat until taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
      samples_in    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res[samples_in] = foc_transform(cur_sample);
        samples_in <= samples_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (sample_q[0].drain_first &&
                     (s_axis_tvalid || samples_in != results_out)) begin
          s_axis_tvalid <= 1'b0;
        end else if (idle_allowed && !sample_q[0].drain_first &&
                     $urandom_range(0, 7) == 0) begin
          send_gap      <= $urandom_range(0, 13);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_sample = sample_q[0].smp;
          sample_q.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_sample.mode;
          // cos_angle, sin_angle, axis_d, axis_q, phase_c, phase_b, phase_a
          s_axis_tdata  <= TDW'({cur_sample.cos_angle, cur_sample.sin_angle,
                                 cur_sample.axis_d, cur_sample.axis_q,
                                 cur_sample.phase_c, cur_sample.phase_b,
                                 cur_sample.phase_a});
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off, result checking
  always @(posedge clk) begin
    fcps_pkg::res_t exp_r;
    if (rst) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= 0;
      results_out    <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_out >= samples_in) begin
          $error("result beat with no sample set outstanding");
          mismatches++;
        end else begin
          exp_r = expected_res[results_out];
          expected_res.delete(results_out);
          check_field("out_alpha", exp_r.out_alpha, m_axis_tdata[0*DW +: DW]);
          check_field("out_beta",  exp_r.out_beta,  m_axis_tdata[1*DW +: DW]);
          check_field("out_q",     exp_r.out_q,     m_axis_tdata[2*DW +: DW]);
          check_field("out_d",     exp_r.out_d,     m_axis_tdata[3*DW +: DW]);
          check_field("out_a",     exp_r.out_a,     m_axis_tdata[4*DW +: DW]);
          check_field("out_b",     exp_r.out_b,     m_axis_tdata[5*DW +: DW]);
          check_field("out_c",     exp_r.out_c,     m_axis_tdata[6*DW +: DW]);
          results_out <= results_out + 1;
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && samples_in >= LONG_HOLD_AT) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD - 1;
        m_axis_tready  <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
        hold_left     <= $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("foc_clarke_park_svpwm_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // forward: zero, unit-ish angle
    add_sample(fcps_pkg::MODE_FWD, 0, 0, 0, 0, 0, 0, 32767, 0);
    // forward: alpha saturates high and low, full-scale angle
    add_sample(fcps_pkg::MODE_FWD, 32767, -32768, -32768, 0, 0, -32768, -32768, 0);
    add_sample(fcps_pkg::MODE_FWD, -32768, 32767, 32767, 0, 0, 32767, -32768, 0);
    // forward: beta saturates both ways
    add_sample(fcps_pkg::MODE_FWD, 0, 32767, -32768, 0, 0, -32768, 32767, 0);
    add_sample(fcps_pkg::MODE_FWD, 0, -32768, 32767, 0, 0, 32767, 32767, 0);
    // forward: balanced full scale, small rounding values
    add_sample(fcps_pkg::MODE_FWD, -32768, -32768, -32768, 0, 0, -32768, -32768, 0);
    add_sample(fcps_pkg::MODE_FWD, 32767, 32767, 32767, 0, 0, 32767, 32767, 0);
    add_sample(fcps_pkg::MODE_FWD, 1, 0, 0, 0, 0, 16384, 16384, 0);
    add_sample(fcps_pkg::MODE_FWD, -1, 1, 0, 0, 0, -1, 1, 0);
    // forward with the inverse-only fields populated
    add_sample(fcps_pkg::MODE_FWD, 12000, -5000, -7000, -32768, 32767, 23170, 23170, 0);
    // inverse: zero, full-scale products and sums
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 0, 0, 0, 32767, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, -32768, -32768, -32768, -32768, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 32767, -32768, 32767, -32768, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, -32768, 32767, -32768, 32767, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 32767, 32767, 32767, 32767, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 32767, 0, 0, 32767, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 0, 32767, 32767, 0, 0);
    add_sample(fcps_pkg::MODE_INV, 0, 0, 0, 1, -1, 16384, -16384, 0);
    // inverse with the forward-only fields populated
    add_sample(fcps_pkg::MODE_INV, -32768, 32767, 1234, 20000, -15000, -23170, 23170, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_sample($urandom_range(0, 1) ? fcps_pkg::MODE_INV : fcps_pkg::MODE_FWD,
                 rand_field(), rand_field(), rand_field(), rand_field(),
                 rand_field(), rand_field(), rand_field(),
                 (i == 150 || i == 560));
    end
    n_items = sample_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || s_axis_tvalid || results_out != samples_in) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("foc_clarke_park_svpwm_unit verification clean");
    end else begin
      $display("foc_clarke_park_svpwm_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fcps_pkg.sv
hdl/fcps_front.sv
hdl/fcps_back.sv
hdl/foc_clarke_park_svpwm_unit.sv
tb/sv/tb.sv
